[rtl/qfrp_pkg.sv]
`timescale 1ns / 1ps

package qfrp_pkg;

    // Fixed-point and sizing constants
    localparam int FRAC_BITS   = 16;
    localparam int POLY_TERMS  = 36;
    localparam int OUT_DIMS    = 3;
    localparam int NFEAT       = 7;
    localparam int LIN_TERMS   = NFEAT + 1;
    localparam int STORE_DEPTH = POLY_TERMS * OUT_DIMS;

    localparam int COORD_W  = 32;
    localparam int DMAG_W   = 33;
    localparam int SUMSQ_W  = 66;
    localparam int ROOT_W   = 33;
    localparam int REM_W    = ROOT_W + 2;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int FEAT_W   = 35;
    localparam int TERM_W   = 52;
    localparam int ACC_W    = 96;
    localparam int WADDR_W  = $clog2(STORE_DEPTH);
    localparam int TADDR_W  = $clog2(POLY_TERMS);
    localparam int FIDX_W   = $clog2(NFEAT);

    // Shared multiplier: wide operand split in two halves
    localparam int MUL_HALF_W = 28;
    localparam int MUL_A_W    = 2 * MUL_HALF_W;
    localparam int MUL_B_W    = 35;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [TERM_W-1:0] BIAS_TERM = TERM_W'(1) << FRAC_BITS;

    // Commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PREDICT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNTRAINED = 2'd1;
    localparam logic [1:0] ST_ROWS      = 2'd2;
    localparam logic [1:0] ST_ZERO_DIST = 2'd3;

    typedef struct packed {
        logic                      command;
        logic [6:0]                weight_index;
        logic signed [COORD_W-1:0] weight_value;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
    } qfrp_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pred_x;
        logic signed [COORD_W-1:0] pred_y;
        logic signed [COORD_W-1:0] pred_z;
        logic [1:0]                status;
    } qfrp_res_t;

    // Floor shift by FRAC_BITS and clamp to signed 32 bits
    function automatic logic signed [COORD_W-1:0] sat_out(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_BITS-1:0] sh;
        sh = acc[ACC_W-1:FRAC_BITS];
        if ((&sh[ACC_W-FRAC_BITS-1:COORD_W-1]) || !(|sh[ACC_W-FRAC_BITS-1:COORD_W-1])) begin
            return sh[COORD_W-1:0];
        end
        else if (sh[ACC_W-FRAC_BITS-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

[rtl/quadratic_feature_regression_predict_core.sv]
`timescale 1ns / 1ps

// Degree-1/2 polynomial regression predictor. A load request writes one weight
// into the 108-entry weight RAM, and loads are taken back to back. A predict
// request is processed alone: three squares, a square root, three divisions,
// the bias, linear and (degree 2 only) quadratic terms (written to a 36-entry
// term RAM) and the multiply-accumulate over term RAM and weight RAM. One shared
// 28x35 multiplier does every product; a predict that fails its status checks
// skips all of this and goes straight to the result. The result sits in an
// output register, so the next request is accepted while it waits. Weights
// must be written before they are used.
module quadratic_feature_regression_predict_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  qfrp_pkg::qfrp_req_t              req,
    output logic                             res_valid,
    input  logic                             res_stall,
    output qfrp_pkg::qfrp_res_t              res,
    input  logic                             cfg_we,
    input  logic [qfrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [5:0]                       cfg_data
);
    import qfrp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQ   = 8'b0000_0010,
        S_SQRT = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_LIN  = 8'b0001_0000,
        S_QUAD = 8'b0010_0000,
        S_MAC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [1:0]               degree_reg;
    logic [5:0]               rows_reg;
    logic                     wait_reg;
    logic                     rd_ok_reg;
    logic [1:0]               c_reg;
    logic [DMAG_W-1:0]        dmag_reg [3];
    logic [2:0]               dneg_reg;
    logic signed [FEAT_W-1:0] feat_reg [NFEAT];
    logic [SUMSQ_W-1:0]       sumsq_reg;
    logic [FIDX_W-1:0]        j_reg;
    logic [FIDX_W-1:0]        k_reg;
    logic [TADDR_W-1:0]       n_reg;
    logic [WADDR_W-1:0]       w_reg;
    logic signed [FEAT_W-1:0] fj_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg [OUT_DIMS];
    logic [1:0]               status_reg;
    qfrp_res_t                res_reg;
    logic                     res_valid_reg;

    logic                     req_acc;
    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
    logic signed [COORD_W:0]  dl [3];
    logic signed [COORD_W:0]  psum [3];
    logic [DMAG_W-1:0]        dl_mag [3];
    logic [5:0]               nterms;
    logic [1:0]               status_new;

    logic                     mul_start;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic                     mul_neg;
    logic                     mul_done;
    logic [MUL_P_W-1:0]       mul_prod;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;

    logic signed [FEAT_W-1:0] fk;
    logic signed [FEAT_W-1:0] fa;
    logic [FEAT_W-1:0]        fk_mag;
    logic [FEAT_W-1:0]        fa_mag;
    logic [TERM_W-1:0]        t_rdata;
    logic [TERM_W-1:0]        t_mag;
    logic [COORD_W-1:0]       w_rdata;
    logic [COORD_W-1:0]       w_mag;
    logic [TERM_W-1:0]        q_mag;
    logic [TERM_W-1:0]        q_term;
    logic [FIDX_W-1:0]        lin_idx;
    logic signed [FEAT_W-1:0] lin_feat;
    logic signed [ACC_W-1:0]  prod_s;
    logic signed [FEAT_W-1:0] u_feat;

    logic                     tm_we;
    logic [TERM_W-1:0]        tm_wdata;
    logic                     wm_we;

    assign req_acc   = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Request decode: differences, midpoints and status
    always_comb
    begin
        pa[0] = req.ax;
        pa[1] = req.ay;
        pa[2] = req.az;
        pb[0] = req.bx;
        pb[1] = req.by_coord;
        pb[2] = req.bz;
        for (int i = 0; i < 3; i++)
        begin
            dl[i]     = {pb[i][COORD_W-1], pb[i]} - {pa[i][COORD_W-1], pa[i]};
            psum[i]   = {pb[i][COORD_W-1], pb[i]} + {pa[i][COORD_W-1], pa[i]};
            dl_mag[i] = dl[i][COORD_W] ? DMAG_W'(-dl[i]) : DMAG_W'(dl[i]);
        end
        nterms = (degree_reg == 2'd1) ? 6'(LIN_TERMS) : 6'(POLY_TERMS);
        if (rows_reg == 6'd0)
        begin
            status_new = ST_UNTRAINED;
        end
        else if ((degree_reg != 2'd1 && degree_reg != 2'd2) || rows_reg != nterms)
        begin
            status_new = ST_ROWS;
        end
        else if (dl_mag[0] == '0 && dl_mag[1] == '0 && dl_mag[2] == '0)
        begin
            status_new = ST_ZERO_DIST;
        end
        else
        begin
            status_new = ST_OK;
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        fk      = feat_reg[k_reg];
        fa      = (k_reg == j_reg) ? fk : fj_reg;
        fk_mag  = fk[FEAT_W-1] ? FEAT_W'(-fk) : FEAT_W'(fk);
        fa_mag  = fa[FEAT_W-1] ? FEAT_W'(-fa) : FEAT_W'(fa);
        t_mag   = t_rdata[TERM_W-1] ? (~t_rdata + TERM_W'(1)) : t_rdata;
        w_mag   = w_rdata[COORD_W-1] ? (~w_rdata + COORD_W'(1)) : w_rdata;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_start = 1'b0;
        if (state_reg == S_SQ)
        begin
            mul_a     = MUL_A_W'(dmag_reg[c_reg]);
            mul_b     = MUL_B_W'(dmag_reg[c_reg]);
            mul_start = !wait_reg;
        end
        else if (state_reg == S_QUAD)
        begin
            mul_a     = MUL_A_W'(fa_mag);
            mul_b     = MUL_B_W'(fk_mag);
            mul_neg   = fa[FEAT_W-1] ^ fk[FEAT_W-1];
            mul_start = !wait_reg;
        end
        else if (state_reg == S_MAC)
        begin
            mul_a     = MUL_A_W'(t_mag);
            mul_b     = MUL_B_W'(w_mag);
            mul_neg   = t_rdata[TERM_W-1] ^ w_rdata[COORD_W-1];
            mul_start = !wait_reg && rd_ok_reg;
        end
        sqrt_start = (state_reg == S_SQRT) && !wait_reg;
        div_start  = (state_reg == S_DIV) && !wait_reg;
    end

    // Term values and term RAM write port
    always_comb
    begin
        q_mag    = mul_prod[FRAC_BITS +: TERM_W];
        q_term   = neg_reg ? (~q_mag + TERM_W'(1)) : q_mag;
        lin_idx  = n_reg[FIDX_W-1:0] - FIDX_W'(1);
        lin_feat = feat_reg[lin_idx];
        prod_s   = neg_reg ? -$signed(ACC_W'(mul_prod)) : $signed(ACC_W'(mul_prod));
        u_feat   = dneg_reg[c_reg] ? -$signed(FEAT_W'(div_quo)) : $signed(FEAT_W'(div_quo));
        tm_we    = 1'b0;
        tm_wdata = q_term;
        if (state_reg == S_LIN)
        begin
            tm_we    = 1'b1;
            tm_wdata = (n_reg == '0) ? BIAS_TERM
                       : {{(TERM_W-FEAT_W){lin_feat[FEAT_W-1]}}, lin_feat};
        end
        else if (state_reg == S_QUAD && wait_reg && mul_done)
        begin
            tm_we = 1'b1;
        end
        wm_we = req_acc && (req.command == CMD_LOAD)
                && (req.weight_index < WADDR_W'(STORE_DEPTH));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 2'd2;
            rows_reg   <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEGREE: degree_reg <= cfg_data[1:0];
                CFG_ROWS:   rows_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            c_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            w_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    wait_reg <= 1'b0;
                    c_reg    <= '0;
                    if (req_acc && req.command == CMD_PREDICT)
                    begin
                        state_reg <= (status_new == ST_OK) ? S_SQ : S_DONE;
                    end
                end
                S_SQ:
                begin
                    if (mul_start)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        if (c_reg == 2'd2)
                        begin
                            c_reg     <= '0;
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_start)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (sqrt_done)
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_start)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        wait_reg <= 1'b0;
                        if (c_reg == 2'd2)
                        begin
                            c_reg     <= '0;
                            n_reg     <= '0;
                            state_reg <= S_LIN;
                        end
                        else
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end
                end
                S_LIN:
                begin
                    n_reg <= n_reg + TADDR_W'(1);
                    if (n_reg == TADDR_W'(LIN_TERMS - 1))
                    begin
                        if (degree_reg == 2'd2)
                        begin
                            j_reg     <= '0;
                            k_reg     <= '0;
                            state_reg <= S_QUAD;
                        end
                        else
                        begin
                            n_reg     <= '0;
                            w_reg     <= '0;
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_QUAD:
                begin
                    if (mul_start)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        n_reg    <= n_reg + TADDR_W'(1);
                        if (k_reg == FIDX_W'(NFEAT - 1))
                        begin
                            if (j_reg == FIDX_W'(NFEAT - 1))
                            begin
                                n_reg     <= '0;
                                w_reg     <= '0;
                                rd_ok_reg <= 1'b0;
                                state_reg <= S_MAC;
                            end
                            else
                            begin
                                j_reg <= j_reg + FIDX_W'(1);
                                k_reg <= j_reg + FIDX_W'(1);
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + FIDX_W'(1);
                        end
                    end
                end
                S_MAC:
                begin
                    if (!wait_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                        if (mul_start)
                        begin
                            wait_reg  <= 1'b1;
                            rd_ok_reg <= 1'b0;
                        end
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        w_reg    <= w_reg + WADDR_W'(1);
                        if (c_reg == 2'(OUT_DIMS - 1))
                        begin
                            c_reg <= '0;
                            n_reg <= n_reg + TADDR_W'(1);
                            if (n_reg == TADDR_W'(nterms - 6'd1))
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_acc && req.command == CMD_PREDICT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dmag_reg[i] <= dl_mag[i];
                dneg_reg[i] <= dl[i][COORD_W];
                feat_reg[i] <= FEAT_W'($signed(psum[i][COORD_W:1]));
            end
            for (int c = 0; c < OUT_DIMS; c++)
            begin
                acc_reg[c] <= '0;
            end
            sumsq_reg  <= '0;
            status_reg <= status_new;
        end
        if (state_reg == S_SQ && wait_reg && mul_done)
        begin
            sumsq_reg <= sumsq_reg + mul_prod[SUMSQ_W-1:0];
        end
        if (state_reg == S_SQRT && wait_reg && sqrt_done)
        begin
            feat_reg[3] <= FEAT_W'(sqrt_root);
        end
        if (state_reg == S_DIV && wait_reg && div_done)
        begin
            feat_reg[3'd4 + 3'(c_reg)] <= u_feat;
        end
        if (mul_start)
        begin
            neg_reg <= mul_neg;
            if (state_reg == S_QUAD && k_reg == j_reg)
            begin
                fj_reg <= fk;
            end
        end
        if (state_reg == S_MAC && wait_reg && mul_done)
        begin
            acc_reg[c_reg] <= acc_reg[c_reg] + prod_s;
        end
        if (state_reg == S_DONE && (!res_valid_reg || !res_stall))
        begin
            res_reg.status <= status_reg;
            res_reg.pred_x <= (status_reg == ST_OK) ? sat_out(acc_reg[0]) : '0;
            res_reg.pred_y <= (status_reg == ST_OK) ? sat_out(acc_reg[1]) : '0;
            res_reg.pred_z <= (status_reg == ST_OK) ? sat_out(acc_reg[2]) : '0;
        end
    end

    // Weight RAM: written by load requests, read during accumulation
    qfrp_mem #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (COORD_W)
    ) u_wmem (
        .clk   (clk),
        .we    (wm_we),
        .waddr (req.weight_index),
        .wdata (req.weight_value),
        .raddr (w_reg),
        .rdata (w_rdata)
    );

    // Term RAM: bias, linear and quadratic terms
    qfrp_mem #(
        .DEPTH (POLY_TERMS),
        .WIDTH (TERM_W)
    ) u_tmem (
        .clk   (clk),
        .we    (tm_we),
        .waddr (n_reg),
        .wdata (tm_wdata),
        .raddr (n_reg),
        .rdata (t_rdata)
    );

    qfrp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    qfrp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sumsq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    qfrp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dmag_reg[c_reg]),
        .den   (feat_reg[3][ROOT_W-1:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    // A predict request blocks further requests until it finishes
    a_predict_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.command == CMD_PREDICT |=> req_stall)
        else $error("predict request did not block the request channel");

    // Failed status always carries a zero point
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_OK |->
        res.pred_x == '0 && res.pred_y == '0 && res.pred_z == '0)
        else $error("nonzero prediction with failing status");

    // Multiplier finishes only for an operation the sequencer waits on
    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> wait_reg)
        else $error("multiplier result with no pending operation");

    // Weight RAM is written only while idle
    a_wmem_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wm_we |-> state_reg == S_IDLE)
        else $error("weight write during a prediction");

endmodule

[rtl/qfrp_mem.sv]
`timescale 1ns / 1ps

// Single-port-write, single-port-read RAM, registered read
module qfrp_mem #(
    parameter int DEPTH = 36,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/qfrp_mul.sv]
`timescale 1ns / 1ps

// Unsigned multiplier: a partial product for the low half, then for the high half, of operand a
module qfrp_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qfrp_pkg::MUL_A_W-1:0]  a,
    input  logic [qfrp_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [qfrp_pkg::MUL_P_W-1:0]  prod
);
    import qfrp_pkg::*;

    logic [MUL_A_W-1:0]    a_reg;
    logic [MUL_B_W-1:0]    b_reg;
    logic                  busy_reg;
    logic                  hi_reg;
    logic                  done_reg;
    logic [MUL_P_W-1:0]    prod_reg;
    logic [MUL_HALF_W-1:0] half;
    logic [MUL_HALF_W+MUL_B_W-1:0] pp;

    // One partial product per cycle
    always_comb
    begin
        half = hi_reg ? a_reg[MUL_A_W-1:MUL_HALF_W] : a_reg[MUL_HALF_W-1:0];
        pp   = (MUL_HALF_W+MUL_B_W)'(half) * (MUL_HALF_W+MUL_B_W)'(b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            hi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            hi_reg <= 1'b1;
            if (hi_reg)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            if (hi_reg)
            begin
                prod_reg <= prod_reg + (MUL_P_W'(pp) << MUL_HALF_W);
            end
            else
            begin
                prod_reg <= MUL_P_W'(pp);
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[rtl/qfrp_sqrt.sv]
`timescale 1ns / 1ps

// Restoring integer square root, one root bit per cycle
module qfrp_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qfrp_pkg::SUMSQ_W-1:0]  rad,
    output logic                          done,
    output logic [qfrp_pkg::ROOT_W-1:0]   root
);
    import qfrp_pkg::*;

    logic [SUMSQ_W-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               ge;
    logic [REM_W+1:0]   rem_new;

    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[SUMSQ_W-1:SUMSQ_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
        rem_new = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SUMSQ_W-3:0], 2'b00};
            rem_reg  <= rem_new[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/qfrp_div.sv]
`timescale 1ns / 1ps

// Restoring divider for (num << FRAC_BITS) / den with num <= den
module qfrp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [qfrp_pkg::DMAG_W-1:0]  num,
    input  logic [qfrp_pkg::ROOT_W-1:0]  den,
    output logic                         done,
    output logic [qfrp_pkg::QUO_W-1:0]   quo
);
    import qfrp_pkg::*;

    logic [ROOT_W:0]   r_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic [ROOT_W:0]   r_new;

    always_comb
    begin
        ge    = (r_reg >= {1'b0, den_reg});
        r_new = ge ? (r_reg - {1'b0, den_reg}) : r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= (ROOT_W+1)'(num);
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= {r_new[ROOT_W-1:0], 1'b0};
            q_reg <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
